@@ rtl/pps_pkg.sv @@
// Shared types and constants of the precedence parse stack unit.
package pps_pkg;

  // Default sizes of the stack and of the stored codes
  localparam int unsigned DEF_STACK_DEPTH = 32;
  localparam int unsigned DEF_CODE_BITS   = 8;

  // Width of the code fields on the stream ports
  localparam int unsigned PORT_CODE_W = 8;

  // Operation carried in the input word
  typedef enum logic [1:0] {
    FUNC_SHIFT   = 2'd0,
    FUNC_PUSH_NT = 2'd1,
    FUNC_REDUCE  = 2'd2,
    FUNC_PUSH_T  = 2'd3
  } func_e;

  // Kind of a stack entry
  typedef enum logic [1:0] {
    KIND_TOKEN   = 2'd0,
    KIND_NONTERM = 2'd1,
    KIND_MARKER  = 2'd2
  } kind_e;

  // Result status
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NO_MARKER = 2'd2,
    ST_EMPTY_SEG = 2'd3
  } status_e;

  // Command broadcast to every stack cell
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_PUSH  = 2'd1,
    CELL_SHIFT = 2'd2
  } cell_op_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_MARK = 2'd1,
    S_EMIT = 2'd2
  } state_e;

endpackage

@@ rtl/precedence_parse_stack_unit.sv @@
// Top level of the precedence parse stack unit: sequencer plus a row of stack cells.
//
// Stack of an operator-precedence parser held in a row of STACK_DEPTH cells, one entry each;
// every cell also remembers the nearest token and marker below it, so a shift moves all
// entries above the insertion point up by one at once. The block takes one word
// at a time. Shift, push nonterminal and push terminal give one result word when accepted.
// A reduce is accepted, then reads the topmost marker's cell, then emits one result word
// per popped entry (one word for an empty segment); a reduce with no marker answers when
// accepted. The single read port on the cell row makes the popped entries come out one
// at a time. Results wait in an output register, and a stall on the master side holds the
// sequencer. There is no clearing pass after reset.
module precedence_parse_stack_unit
  import pps_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int unsigned CODE_BITS   = DEF_CODE_BITS,
  localparam int unsigned FILL_W     = $clog2(STACK_DEPTH + 1),
  localparam int unsigned TDATA_W    = ((19 + FILL_W + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,  // token_code, nonterm_type
  input  logic [1:0]         s_axis_tuser,  // func
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,  // status, elem_value, top_term_valid,
                                            // top_term_code, depth, zero fill
  output logic [2:0]         m_axis_tuser,  // elem_kind, elem_valid
  output logic               m_axis_tlast
);

  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);

  typedef struct packed {
    kind_e                kind;
    logic [CODE_BITS-1:0] value;
    logic                 btv;
    logic [CODE_BITS-1:0] btc;
    logic [IDX_W-1:0]     bti;
    logic                 bmv;
    logic [IDX_W-1:0]     bmi;
  } entry_t;

  typedef struct packed {
    cell_op_e             op;
    logic [FILL_W-1:0]    fill;
    logic [IDX_W-1:0]     pos;
    kind_e                kind;
    logic [CODE_BITS-1:0] value;
    logic                 ttv;
    logic [CODE_BITS-1:0] ttc;
    logic [IDX_W-1:0]     tti;
    logic                 tmv;
    logic [IDX_W-1:0]     tmi;
    logic [IDX_W-1:0]     new_mark;
  } bcast_t;

  entry_t                 cell_entry  [STACK_DEPTH];
  entry_t                 below_entry [STACK_DEPTH];
  entry_t                 rd_entry;
  logic [IDX_W-1:0]       rd_idx;
  bcast_t                 bc;
  status_e                status;
  kind_e                  elem_kind;
  logic [PORT_CODE_W-1:0] elem_value, top_code;
  logic                   elem_valid, top_valid;
  logic [FILL_W-1:0]      depth;

  // Sequencer
  pps_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .CODE_BITS   (CODE_BITS),
    .IDX_W       (IDX_W),
    .FILL_W      (FILL_W),
    .entry_t     (entry_t),
    .bcast_t     (bcast_t)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .func_i       (func_e'(s_axis_tuser)),
    .tok_i        (CODE_BITS'(s_axis_tdata[7:0])),
    .nt_i         (CODE_BITS'(s_axis_tdata[15:8])),
    .rd_entry_i   (rd_entry),
    .rd_idx_o     (rd_idx),
    .bc_o         (bc),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .status_o     (status),
    .kind_o       (elem_kind),
    .value_o      (elem_value),
    .elem_valid_o (elem_valid),
    .last_o       (m_axis_tlast),
    .ttv_o        (top_valid),
    .ttc_o        (top_code),
    .depth_o      (depth)
  );

  // Row of cells, each fed by its lower neighbor
  for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
    if (gi == 0) begin : g_bottom
      assign below_entry[gi] = '0;
    end else begin : g_upper
      assign below_entry[gi] = cell_entry[gi-1];
    end

    pps_cell #(
      .INDEX   (gi),
      .IDX_W   (IDX_W),
      .FILL_W  (FILL_W),
      .entry_t (entry_t),
      .bcast_t (bcast_t)
    ) u_cell (
      .clk_i   (clk_i),
      .bc_i    (bc),
      .below_i (below_entry[gi]),
      .entry_o (cell_entry[gi])
    );
  end

  // Read port on the row
  assign rd_entry = cell_entry[rd_idx];

  // Pack the result word
  assign m_axis_tdata = TDATA_W'({depth, top_code, top_valid, elem_value, status});
  assign m_axis_tuser = {elem_valid, elem_kind};

endmodule

@@ rtl/pps_cell.sv @@
// One stack cell: holds an entry plus the nearest token and marker below it.
module pps_cell
  import pps_pkg::*;
#(
  parameter int unsigned INDEX  = 0,
  parameter int unsigned IDX_W  = 5,
  parameter int unsigned FILL_W = 6,
  parameter type         entry_t = logic,
  parameter type         bcast_t = logic
) (
  input  logic   clk_i,
  input  bcast_t bc_i,
  input  entry_t below_i,
  output entry_t entry_o
);

  localparam logic [FILL_W-1:0] MY_FILL = FILL_W'(INDEX);
  localparam logic [IDX_W-1:0]  MY_IDX  = IDX_W'(INDEX);

  entry_t entry_q, entry_d;

  // Work out the next content of this cell from the broadcast command
  always_comb begin
    entry_d = entry_q;
    case (bc_i.op)
      CELL_PUSH: begin
        if (bc_i.fill == MY_FILL) begin
          entry_d.kind  = bc_i.kind;
          entry_d.value = bc_i.value;
          entry_d.btv   = bc_i.ttv;
          entry_d.btc   = bc_i.ttc;
          entry_d.bti   = bc_i.tti;
          entry_d.bmv   = bc_i.tmv;
          entry_d.bmi   = bc_i.tmi;
        end
      end
      CELL_SHIFT: begin
        if (MY_FILL == bc_i.fill + FILL_W'(1)) begin
          // new token on top
          entry_d.kind  = KIND_TOKEN;
          entry_d.value = bc_i.value;
          entry_d.btv   = bc_i.ttv;
          entry_d.btc   = bc_i.ttc;
          entry_d.bti   = bc_i.tti;
          entry_d.bmv   = 1'b1;
          entry_d.bmi   = bc_i.new_mark;
        end else if (MY_IDX == bc_i.pos) begin
          // inserted marker; keep own marker info if the old top marker sat at or above
          entry_d.kind  = KIND_MARKER;
          entry_d.value = '0;
          entry_d.btv   = bc_i.ttv;
          entry_d.btc   = bc_i.ttc;
          entry_d.bti   = bc_i.tti;
          if (!bc_i.tmv || (bc_i.tmi < bc_i.pos)) begin
            entry_d.bmv = bc_i.tmv;
            entry_d.bmi = bc_i.tmi;
          end
        end else if ((MY_IDX > bc_i.pos) && (MY_FILL <= bc_i.fill)) begin
          // move up from the neighbor and renumber the marker below
          entry_d     = below_i;
          entry_d.bmv = 1'b1;
          if (below_i.bmv && (below_i.bmi >= bc_i.pos)) begin
            entry_d.bmi = below_i.bmi + IDX_W'(1);
          end else begin
            entry_d.bmi = bc_i.pos;
          end
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  // Hold the entry
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

@@ rtl/pps_ctrl.sv @@
// Sequencer: decodes operations, tracks depth and top entries, emits results.
module pps_ctrl
  import pps_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int unsigned CODE_BITS   = DEF_CODE_BITS,
  parameter int unsigned IDX_W       = 5,
  parameter int unsigned FILL_W      = 6,
  parameter type         entry_t     = logic,
  parameter type         bcast_t     = logic
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  func_e                  func_i,
  input  logic [CODE_BITS-1:0]   tok_i,
  input  logic [CODE_BITS-1:0]   nt_i,
  input  entry_t                 rd_entry_i,
  output logic [IDX_W-1:0]       rd_idx_o,
  output bcast_t                 bc_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output status_e                status_o,
  output kind_e                  kind_o,
  output logic [PORT_CODE_W-1:0] value_o,
  output logic                   elem_valid_o,
  output logic                   last_o,
  output logic                   ttv_o,
  output logic [PORT_CODE_W-1:0] ttc_o,
  output logic [FILL_W-1:0]      depth_o
);

  state_e               state_q, state_d;
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [FILL_W-1:0]    end_q, end_d;
  logic [IDX_W-1:0]     rd_q, rd_d;
  logic                 empty_q, empty_d;
  logic                 ttv_q, ttv_d;
  logic [CODE_BITS-1:0] ttc_q, ttc_d;
  logic [IDX_W-1:0]     tti_q, tti_d;
  logic                 tmv_q, tmv_d;
  logic [IDX_W-1:0]     tmi_q, tmi_d;

  logic                 out_valid_q, out_valid_d;
  status_e              o_status_q, o_status_d;
  kind_e                o_kind_q, o_kind_d;
  logic [CODE_BITS-1:0] o_value_q, o_value_d;
  logic                 o_elem_q, o_elem_d;
  logic                 o_last_q, o_last_d;
  logic                 o_ttv_q;
  logic [CODE_BITS-1:0] o_ttc_q;
  logic [FILL_W-1:0]    o_depth_q;

  logic                 slot_free, in_fire, load, emit_last;
  logic                 shift_full, push_full;
  logic [IDX_W-1:0]     pos, new_mark;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && slot_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign emit_last  = (FILL_W'(rd_q) + FILL_W'(1)) == end_q;
  assign shift_full = ({1'b0, fill_q} + (FILL_W + 1)'(2)) > (FILL_W + 1)'(STACK_DEPTH);
  assign push_full  = fill_q == FILL_W'(STACK_DEPTH);

  // Marker goes just above the topmost token, or to the bottom
  assign pos      = ttv_q ? tti_q + IDX_W'(1) : '0;
  assign new_mark = (tmv_q && (tmi_q >= pos)) ? tmi_q + IDX_W'(1) : pos;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && (func_i == FUNC_REDUCE) && tmv_q) state_d = S_MARK;
      end
      S_MARK: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free && (empty_q || emit_last)) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath, cell commands and result loading
  always_comb begin
    fill_d     = fill_q;
    end_d      = end_q;
    rd_d       = rd_q;
    empty_d    = empty_q;
    ttv_d      = ttv_q;
    ttc_d      = ttc_q;
    tti_d      = tti_q;
    tmv_d      = tmv_q;
    tmi_d      = tmi_q;
    rd_idx_o   = rd_q;
    load       = 1'b0;
    o_status_d = ST_OK;
    o_kind_d   = KIND_TOKEN;
    o_value_d  = '0;
    o_elem_d   = 1'b0;
    o_last_d   = 1'b1;

    bc_o.op       = CELL_HOLD;
    bc_o.fill     = fill_q;
    bc_o.pos      = pos;
    bc_o.kind     = KIND_TOKEN;
    bc_o.value    = tok_i;
    bc_o.ttv      = ttv_q;
    bc_o.ttc      = ttc_q;
    bc_o.tti      = tti_q;
    bc_o.tmv      = tmv_q;
    bc_o.tmi      = tmi_q;
    bc_o.new_mark = new_mark;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (func_i) inside
            FUNC_SHIFT: begin
              load = 1'b1;
              if (shift_full) begin
                o_status_d = ST_FULL;
              end else begin
                bc_o.op = CELL_SHIFT;
                fill_d  = fill_q + FILL_W'(2);
                ttv_d   = 1'b1;
                ttc_d   = tok_i;
                tti_d   = IDX_W'(fill_q + FILL_W'(1));
                tmv_d   = 1'b1;
                tmi_d   = new_mark;
              end
            end
            FUNC_PUSH_NT, FUNC_PUSH_T: begin
              load = 1'b1;
              if (push_full) begin
                o_status_d = ST_FULL;
              end else begin
                bc_o.op = CELL_PUSH;
                fill_d  = fill_q + FILL_W'(1);
                if (func_i == FUNC_PUSH_NT) begin
                  bc_o.kind  = KIND_NONTERM;
                  bc_o.value = nt_i;
                end else begin
                  ttv_d = 1'b1;
                  ttc_d = tok_i;
                  tti_d = IDX_W'(fill_q);
                end
              end
            end
            FUNC_REDUCE: begin
              if (!tmv_q) begin
                load       = 1'b1;
                o_status_d = ST_NO_MARKER;
              end
            end
            default: begin
              load = 1'b0;
            end
          endcase
        end
      end
      S_MARK: begin
        // Pop down to the marker; its cell knows what lies below it
        rd_idx_o = tmi_q;
        ttv_d    = rd_entry_i.btv;
        ttc_d    = rd_entry_i.btc;
        tti_d    = rd_entry_i.bti;
        tmv_d    = rd_entry_i.bmv;
        tmi_d    = rd_entry_i.bmi;
        fill_d   = FILL_W'(tmi_q);
        end_d    = fill_q;
        rd_d     = tmi_q + IDX_W'(1);
        empty_d  = (FILL_W'(tmi_q) + FILL_W'(1)) == fill_q;
      end
      S_EMIT: begin
        rd_idx_o = rd_q;
        if (slot_free) begin
          load = 1'b1;
          if (empty_q) begin
            o_status_d = ST_EMPTY_SEG;
          end else begin
            o_kind_d  = rd_entry_i.kind;
            o_value_d = rd_entry_i.value;
            o_elem_d  = 1'b1;
            o_last_d  = emit_last;
            rd_d      = rd_q + IDX_W'(1);
          end
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  assign out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      end_q       <= '0;
      rd_q        <= '0;
      empty_q     <= 1'b0;
      ttv_q       <= 1'b0;
      ttc_q       <= '0;
      tti_q       <= '0;
      tmv_q       <= 1'b0;
      tmi_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      end_q       <= end_d;
      rd_q        <= rd_d;
      empty_q     <= empty_d;
      ttv_q       <= ttv_d;
      ttc_q       <= ttc_d;
      tti_q       <= tti_d;
      tmv_q       <= tmv_d;
      tmi_q       <= tmi_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result word register; tops and depth show the state after the operation
  always_ff @(posedge clk_i) begin
    if (load) begin
      o_status_q <= o_status_d;
      o_kind_q   <= o_kind_d;
      o_value_q  <= o_value_d;
      o_elem_q   <= o_elem_d;
      o_last_q   <= o_last_d;
      o_ttv_q    <= ttv_d;
      o_ttc_q    <= ttv_d ? ttc_d : '0;
      o_depth_q  <= fill_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = o_status_q;
  assign kind_o       = o_kind_q;
  assign value_o      = PORT_CODE_W'(o_value_q);
  assign elem_valid_o = o_elem_q;
  assign last_o       = o_last_q;
  assign ttv_o        = o_ttv_q;
  assign ttc_o        = PORT_CODE_W'(o_ttc_q);
  assign depth_o      = o_depth_q;

endmodule

@@ tb/pps_checker.sv @@
// Scoreboard for the precedence parse stack unit: predicts each result word and compares it.
`timescale 1ns / 100ps
module pps_checker
  import pps_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int unsigned CODE_BITS   = DEF_CODE_BITS,
  localparam int unsigned FILL_W     = $clog2(STACK_DEPTH + 1),
  localparam int unsigned TDATA_W    = ((19 + FILL_W + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,  // token_code, nonterm_type
  input  logic [1:0]         s_axis_tuser,  // func
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [TDATA_W-1:0] m_axis_tdata,  // status, elem_value, top_term_valid,
                                            // top_term_code, depth, zero fill
  input  logic [2:0]         m_axis_tuser,  // elem_kind, elem_valid
  input  logic               m_axis_tlast,
  output int unsigned        err_count_o,
  output int unsigned        pending_o
);

  localparam logic [PORT_CODE_W-1:0] CODE_MASK = PORT_CODE_W'((1 << CODE_BITS) - 1);

  // One expected result word
  typedef struct packed {
    status_e                status;
    kind_e                  kind;
    logic [PORT_CODE_W-1:0] value;
    logic                   valid;
    logic                   last;
    logic                   top_valid;
    logic [PORT_CODE_W-1:0] top_code;
    logic [FILL_W-1:0]      depth;
  } reply_t;

  reply_t                 replies_q[$];
  kind_e                  cell_kind[STACK_DEPTH];
  logic [PORT_CODE_W-1:0] cell_code[STACK_DEPTH];
  int unsigned            fill = 0;
  int unsigned            errors = 0;

  assign err_count_o = errors;

  // Queue a result word that shows the stack as it stands now
  function automatic void queue_reply(status_e st, kind_e k, logic [PORT_CODE_W-1:0] v,
                                      logic vld, logic lst);
    reply_t r;
    r.status    = st;
    r.kind      = k;
    r.value     = v;
    r.valid     = vld;
    r.last      = lst;
    r.top_valid = 1'b0;
    r.top_code  = '0;
    for (int i = int'(fill) - 1; i >= 0; i--) begin
      if (cell_kind[i] == KIND_TOKEN) begin
        r.top_valid = 1'b1;
        r.top_code  = cell_code[i];
        break;
      end
    end
    r.depth = FILL_W'(fill);
    replies_q.push_back(r);
  endfunction

  // Apply one accepted word to the stack copy and queue what it produces
  function automatic void apply_word(func_e op, logic [PORT_CODE_W-1:0] tok_in,
                                     logic [PORT_CODE_W-1:0] nt_in);
    logic [PORT_CODE_W-1:0] tok;
    logic [PORT_CODE_W-1:0] nt;
    int                     pos;
    int                     mark;
    int                     old;
    tok = tok_in & CODE_MASK;
    nt  = nt_in & CODE_MASK;
    case (op)
      FUNC_SHIFT: begin
        if (fill + 2 > STACK_DEPTH) begin
          queue_reply(ST_FULL, KIND_TOKEN, '0, 1'b0, 1'b1);
        end else begin
          // marker goes right above the topmost token, or at the bottom
          pos = 0;
          for (int i = int'(fill) - 1; i >= 0; i--) begin
            if (cell_kind[i] == KIND_TOKEN) begin
              pos = i + 1;
              break;
            end
          end
          for (int i = int'(fill); i > pos; i--) begin
            cell_kind[i] = cell_kind[i-1];
            cell_code[i] = cell_code[i-1];
          end
          cell_kind[pos]    = KIND_MARKER;
          cell_code[pos]    = '0;
          cell_kind[fill+1] = KIND_TOKEN;
          cell_code[fill+1] = tok;
          fill += 2;
          queue_reply(ST_OK, KIND_TOKEN, '0, 1'b0, 1'b1);
        end
      end
      FUNC_PUSH_NT, FUNC_PUSH_T: begin
        if (fill + 1 > STACK_DEPTH) begin
          queue_reply(ST_FULL, KIND_TOKEN, '0, 1'b0, 1'b1);
        end else begin
          cell_kind[fill] = (op == FUNC_PUSH_NT) ? KIND_NONTERM : KIND_TOKEN;
          cell_code[fill] = (op == FUNC_PUSH_NT) ? nt : tok;
          fill++;
          queue_reply(ST_OK, KIND_TOKEN, '0, 1'b0, 1'b1);
        end
      end
      default: begin
        // reduce: pop back to the topmost marker
        mark = -1;
        for (int i = int'(fill) - 1; i >= 0; i--) begin
          if (cell_kind[i] == KIND_MARKER) begin
            mark = i;
            break;
          end
        end
        if (mark < 0) begin
          queue_reply(ST_NO_MARKER, KIND_TOKEN, '0, 1'b0, 1'b1);
        end else if (mark + 1 == int'(fill)) begin
          fill = mark;
          queue_reply(ST_EMPTY_SEG, KIND_TOKEN, '0, 1'b0, 1'b1);
        end else begin
          old  = fill;
          fill = mark;
          for (int i = mark + 1; i < old; i++) begin
            queue_reply(ST_OK, cell_kind[i], cell_code[i], 1'b1, i == old - 1);
          end
        end
      end
    endcase
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Predict on every accepted input word, compare on every accepted result word
  always @(posedge clk_i) begin : watch
    reply_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_word(func_e'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[15:8]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (replies_q.size() == 0) begin
          $display("%0t: result word with nothing expected: tdata %h tuser %h tlast %b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          errors++;
        end else begin
          want = replies_q.pop_front();
          check_field("status", want.status, m_axis_tdata[1:0]);
          check_field("elem_value", want.value, m_axis_tdata[9:2]);
          check_field("top_term_valid", want.top_valid, m_axis_tdata[10]);
          check_field("top_term_code", want.top_code, m_axis_tdata[18:11]);
          check_field("depth", want.depth, m_axis_tdata[19 +: FILL_W]);
          check_field("elem_kind", want.kind, m_axis_tuser[1:0]);
          check_field("elem_valid", want.valid, m_axis_tuser[2]);
          check_field("last", want.last, m_axis_tlast);
        end
      end
      pending_o <= replies_q.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
// Testbench top: clock, reset, stimulus and verdict for the precedence parse stack unit.
`timescale 1ns / 100ps
module testbench;
  import pps_pkg::*;

  localparam int unsigned STACK_DEPTH  = DEF_STACK_DEPTH;
  localparam int unsigned FILL_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned TDATA_W      = ((19 + FILL_W + 7) / 8) * 8;
  localparam int unsigned RANDOM_WORDS = 360;
  localparam int unsigned ROOM         = 24;    // depth bound that shifts and pushes inside open frames may reach
  localparam int unsigned MAX_FILLS    = 3;
  localparam int unsigned HOLD_AT      = 60;    // result count at which the long stall starts
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               s_valid = 1'b0;
  logic               s_ready;
  logic [15:0]        s_data = '0;        // token_code, nonterm_type
  logic [1:0]         s_user = '0;        // func
  logic               m_valid;
  logic               m_ready = 1'b0;
  logic [TDATA_W-1:0] m_data;
  logic [2:0]         m_user;
  logic               m_last;
  int unsigned        err_count;
  int unsigned        pending;
  int unsigned        quiet_cycles = 0;
  int unsigned        words_sent = 0;
  int unsigned        words_taken = 0;
  bit                 send_burst = 1'b0;
  bit                 take_burst = 1'b0;

  // Open shift frames: entries each one added, an upper bound on what its reduce pops
  int unsigned        frame_q[$];
  int unsigned        base_nt = 0;
  int unsigned        depth_bound = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  precedence_parse_stack_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last)
  );

  pps_checker scoreboard (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last),
    .err_count_o   (err_count),
    .pending_o     (pending)
  );

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(func_e op, logic [7:0] tok, logic [7:0] nt);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {nt, tok};
    s_user  <= op;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic do_shift(logic [7:0] tok);
    send_word(FUNC_SHIFT, tok, 8'($urandom_range(0, 255)));
    if (depth_bound + 2 <= STACK_DEPTH) begin
      frame_q.push_back(2);
      depth_bound += 2;
    end
  endtask

  task automatic do_push(func_e op, logic [7:0] code);
    if (op == FUNC_PUSH_NT) send_word(op, 8'($urandom_range(0, 255)), code);
    else send_word(op, code, 8'($urandom_range(0, 255)));
    if (depth_bound + 1 <= STACK_DEPTH) begin
      if (frame_q.size() != 0) frame_q[$] += 1;
      else base_nt++;
      depth_bound++;
    end
  endtask

  task automatic do_reduce();
    send_word(FUNC_REDUCE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    if (frame_q.size() != 0) begin
      depth_bound -= frame_q.pop_back();
      // closing the outermost frame clears the stack, base nonterminals included
      if (frame_q.size() == 0) begin
        depth_bound = 0;
        base_nt     = 0;
      end
    end
  endtask

  // Count cycles in which no word moves on either side
  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: random stalls, one long hold-off to back the block up
  initial begin : receiver
    int unsigned gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) take_burst = !take_burst;
      gap = take_burst ? 0 : $urandom_range(0, 8);
      if (words_taken == HOLD_AT) gap += HOLD_CYCLES;
      if (gap != 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_ready <= 1'b1;
      @(posedge clk);
      while (!m_valid) @(posedge clk);
      words_taken++;
    end
  end

  initial begin : stimulus
    int unsigned first_random;
    int unsigned fills;
    int unsigned r;
    fills = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reduce on an empty stack and with no marker
    do_reduce();
    do_push(FUNC_PUSH_NT, 8'hFF);
    do_reduce();
    // shift with no token below puts the marker at the bottom
    do_shift(8'h00);
    do_push(FUNC_PUSH_T, 8'hFF);
    do_push(FUNC_PUSH_NT, 8'h00);
    // shift moves the nonterminal above the topmost token up past the new marker
    do_shift(8'hA5);
    do_push(FUNC_PUSH_NT, 8'h5A);
    do_reduce();
    do_reduce();
    // single-entry segment
    do_shift(8'h81);
    do_reduce();
    // nested handles, then a stray reduce
    do_shift(8'h7E);
    do_shift(8'h42);
    do_push(FUNC_PUSH_T, 8'h00);
    do_reduce();
    do_reduce();
    do_reduce();

    // Random parsing, with fill-to-full episodes from an empty stack
    first_random = words_sent;
    while (words_sent - first_random < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (frame_q.size() == 0 && base_nt == 0 && fills < MAX_FILLS &&
          (fills == 0 || r < 4)) begin
        // shift, then push up to one free entry: shift no longer fits
        do_shift(8'($urandom_range(0, 255)));
        repeat (STACK_DEPTH - 3) begin
          do_push($urandom_range(0, 1) ? FUNC_PUSH_T : FUNC_PUSH_NT,
                  8'($urandom_range(0, 255)));
        end
        do_shift(8'($urandom_range(0, 255)));
        do_push(FUNC_PUSH_NT, 8'($urandom_range(0, 255)));
        do_push(FUNC_PUSH_T, 8'($urandom_range(0, 255)));
        do_shift(8'($urandom_range(0, 255)));
        // pop the whole stack in one reduce
        do_reduce();
        fills++;
      end else if (frame_q.size() == 0) begin
        if (r < 10) do_reduce();
        else if (r < 30 && base_nt < 4) do_push(FUNC_PUSH_NT, 8'($urandom_range(0, 255)));
        else do_shift(8'($urandom_range(0, 255)));
      end else if (r < 28 && depth_bound + 2 <= ROOM) begin
        do_shift(8'($urandom_range(0, 255)));
      end else if (r < 62 && depth_bound + 1 <= ROOM) begin
        do_push(r[0] ? FUNC_PUSH_T : FUNC_PUSH_NT, 8'($urandom_range(0, 255)));
      end else begin
        do_reduce();
      end
    end
    s_valid <= 1'b0;

    // Wait for every expected word, then a little longer for strays
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
